// ===== hdl/npt_pkg.sv =====
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants for the neighbour prefetch tag cache.
// ----------------------------------------------------------------------------
package npt_pkg;

  localparam int CNT_W         = 16;
  localparam int NUM_SLOTS     = 3;
  localparam int SLOT_W        = 2;
  localparam int PAGE_BITS_DEF = 16;

  // request type codes
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_DONE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic commit;
  } npt_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } npt_sts_t;

  typedef struct packed {
    logic              hit;
    logic              fetch_now;
    logic              stored;
    logic [SLOT_W-1:0] slot_used;
    logic              prefetch_issue;
    logic [CNT_W-1:0]  prefetch_page;
    logic              out_of_range;
  } npt_rsp_t;

endpackage

// ===== hdl/npt_if.sv =====
// ----------------------------------------------------------------------------
// npt channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface npt_req_if #(
  parameter int PAGE_BITS = npt_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [PAGE_BITS-1:0] page_index;

  modport source (output valid, req_type, page_index, input ready);
  modport sink   (input valid, req_type, page_index, output ready);
endinterface

interface npt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        fetch_now;
  logic                        stored;
  logic [npt_pkg::SLOT_W-1:0]  slot_used;
  logic                        prefetch_issue;
  logic [npt_pkg::CNT_W-1:0]   prefetch_page;
  logic                        out_of_range;

  modport source (output valid, hit, fetch_now, stored, slot_used, prefetch_issue,
                  prefetch_page, out_of_range, input ready);
  modport sink   (input valid, hit, fetch_now, stored, slot_used, prefetch_issue,
                  prefetch_page, out_of_range, output ready);
endinterface

interface npt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [npt_pkg::CNT_W-1:0] page_count;

  modport source (output valid, page_count, input ready);
  modport sink   (input valid, page_count, output ready);
endinterface

// ===== hdl/neighbor_prefetch_tag_cache.sv =====
// ----------------------------------------------------------------------------
// neighbor_prefetch_tag_cache
// Three-slot tag cache with circular neighbour prefetch.
// ----------------------------------------------------------------------------
// Each transaction is accepted in ST_IDLE; in ST_EXEC the tag compares,
// insert and prefetch choice are combinational and registered on commit. A
// completion that arrives while the current page is not below page_count
// first goes through ST_DIV, where the bit-serial remainder unit reduces the
// current page into range. One transaction is in work at a time; the next is
// accepted while a finished response still waits in the output register.
// page_count is written through the cfg channel, which is always ready, and
// must only be changed while the block is idle.
module neighbor_prefetch_tag_cache #(
  parameter int PAGE_BITS = npt_pkg::PAGE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  npt_cfg_if.sink    cfg,
  npt_req_if.sink    req,
  npt_rsp_if.source  rsp
);

  npt_pkg::npt_cmd_t cmd;
  npt_pkg::npt_sts_t sts;
  npt_pkg::npt_rsp_t result;
  logic              req_ready;
  logic              rsp_valid;
  logic              cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  npt_dp #(
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_page_count (cfg.page_count),
    .in_req_type    (req.req_type),
    .in_page_index  (req.page_index),
    .result         (result)
  );

  assign req.ready          = req_ready;
  assign rsp.valid          = rsp_valid;
  assign rsp.hit            = result.hit;
  assign rsp.fetch_now      = result.fetch_now;
  assign rsp.stored         = result.stored;
  assign rsp.slot_used      = result.slot_used;
  assign rsp.prefetch_issue = result.prefetch_issue;
  assign rsp.prefetch_page  = result.prefetch_page;
  assign rsp.out_of_range   = result.out_of_range;

endmodule

// ===== hdl/npt_mod.sv =====
// ----------------------------------------------------------------------------
// npt_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module npt_mod #(
  parameter int PAGE_BITS = npt_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [PAGE_BITS-1:0]      dividend,
  input  logic [npt_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [npt_pkg::CNT_W-1:0] rem
);

  localparam int CW = $clog2(PAGE_BITS + 1);

  logic                      run;
  logic [CW-1:0]             cnt;
  logic [PAGE_BITS-1:0]      sh;
  logic [npt_pkg::CNT_W:0]   trial;
  logic [npt_pkg::CNT_W:0]   diff;

  assign trial = {rem, sh[PAGE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(PAGE_BITS);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (run) begin
      sh <= sh << 1;
      // trial stays below twice the divisor, so one subtract is enough
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[npt_pkg::CNT_W-1:0];
      end else begin
        rem <= trial[npt_pkg::CNT_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/npt_dp.sv =====
// ----------------------------------------------------------------------------
// npt_dp
// Datapath: item and slot registers, tag compares, insert and prefetch choice.
// ----------------------------------------------------------------------------
module npt_dp #(
  parameter int PAGE_BITS = npt_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  npt_pkg::npt_cmd_t         cmd,
  output npt_pkg::npt_sts_t         sts,
  input  logic                      cfg_we,
  input  logic [npt_pkg::CNT_W-1:0] cfg_page_count,
  input  logic                      in_req_type,
  input  logic [PAGE_BITS-1:0]      in_page_index,
  output npt_pkg::npt_rsp_t         result
);

  localparam int CW    = npt_pkg::CNT_W;
  localparam int NS    = npt_pkg::NUM_SLOTS;
  localparam int SW    = npt_pkg::SLOT_W;
  localparam int CMP_W = (PAGE_BITS > CW) ? PAGE_BITS : CW;

  logic [CW-1:0]        page_count;
  logic                 item_type;
  logic [PAGE_BITS-1:0] item_page;
  logic [PAGE_BITS-1:0] cur;
  logic                 busy;
  logic                 rem_valid;
  logic [NS-1:0]        slot_valid;
  logic [PAGE_BITS-1:0] slot_page [NS];

  logic                 div_done;
  logic [CW-1:0]        div_rem;

  logic                 oor;
  logic                 cur_lt;
  logic                 is_access;
  logic [PAGE_BITS-1:0] cur_new;
  logic [CW-1:0]        base;
  logic [CW:0]          base_inc;
  logic [CW-1:0]        nx;
  logic [CW-1:0]        pv;
  logic [NS-1:0]        match_vec;
  logic [NS-1:0]        free_vec;
  logic [SW-1:0]        match_slot;
  logic [SW-1:0]        free_slot;
  logic [SW-1:0]        dest;
  logic                 any_match;
  logic                 any_free;
  logic                 ins_ok;
  logic                 do_insert;
  logic [NS-1:0]        valid_n;
  logic [PAGE_BITS-1:0] page_n [NS];
  logic                 nx_cached;
  logic                 pv_cached;
  logic                 busy_mid;
  logic                 issue;
  logic                 hit;
  npt_pkg::npt_rsp_t    res_next;

  function automatic logic wanted(input logic [PAGE_BITS-1:0] p,
                                  input logic [PAGE_BITS-1:0] c,
                                  input logic [CW-1:0]        n,
                                  input logic [CW-1:0]        v);
    logic [CMP_W-1:0] pe;
    pe = CMP_W'(p);
    return (pe == CMP_W'(c)) || (pe == CMP_W'(n)) || (pe == CMP_W'(v));
  endfunction

  npt_mod #(
    .PAGE_BITS (PAGE_BITS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cur),
    .divisor  (page_count),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign oor       = CMP_W'(item_page) >= CMP_W'(page_count);
  assign cur_lt    = CMP_W'(cur) < CMP_W'(page_count);
  assign is_access = (item_type == npt_pkg::REQ_ACCESS);

  assign sts.need_div = !is_access && !oor && !cur_lt && !rem_valid;
  assign sts.div_done = div_done;

  // neighbours come from the current page reduced into range
  assign cur_new  = is_access ? item_page : cur;
  assign base     = is_access ? CW'(item_page) : (cur_lt ? CW'(cur) : div_rem);
  assign base_inc = {1'b0, base} + (CW + 1)'(1);
  assign nx       = (base_inc == {1'b0, page_count}) ? '0 : base_inc[CW-1:0];
  assign pv       = (base == '0) ? page_count - CW'(1) : base - CW'(1);

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      match_vec[i] = slot_valid[i] && (slot_page[i] == item_page);
      free_vec[i]  = !slot_valid[i] || !wanted(slot_page[i], cur_new, nx, pv);
    end
    match_slot = '0;
    free_slot  = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_slot = SW'(i);
      end
      if (free_vec[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  assign any_match = |match_vec;
  assign any_free  = |free_vec;
  assign hit       = is_access && any_match;
  assign ins_ok    = wanted(item_page, cur_new, nx, pv);
  assign dest      = any_match ? match_slot : free_slot;
  assign do_insert = !oor && !hit && ins_ok && (any_match || any_free);

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (do_insert && (dest == SW'(i))) begin
        valid_n[i] = 1'b1;
        page_n[i]  = item_page;
      end else begin
        valid_n[i] = slot_valid[i];
        page_n[i]  = slot_page[i];
      end
    end
    nx_cached = 1'b0;
    pv_cached = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (valid_n[i] && (CMP_W'(page_n[i]) == CMP_W'(nx))) begin
        nx_cached = 1'b1;
      end
      if (valid_n[i] && (CMP_W'(page_n[i]) == CMP_W'(pv))) begin
        pv_cached = 1'b1;
      end
    end
  end

  assign busy_mid = is_access ? busy : 1'b0;
  assign issue    = !busy_mid && !(nx_cached && pv_cached);

  always_comb begin
    res_next = '0;
    if (oor) begin
      res_next.out_of_range = 1'b1;
    end else begin
      res_next.hit            = hit;
      res_next.fetch_now      = is_access && !hit;
      res_next.stored         = do_insert;
      res_next.slot_used      = hit ? match_slot : (do_insert ? dest : '0);
      res_next.prefetch_issue = issue;
      res_next.prefetch_page  = issue ? (nx_cached ? pv : nx) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= CW'(1);
      cur        <= '0;
      busy       <= 1'b0;
      rem_valid  <= 1'b0;
      slot_valid <= '0;
      for (int i = 0; i < NS; i++) begin
        slot_page[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        page_count <= cfg_page_count;
      end
      if (cmd.load_item) begin
        rem_valid <= 1'b0;
      end else if (div_done) begin
        rem_valid <= 1'b1;
      end
      if (cmd.commit && !oor) begin
        cur        <= cur_new;
        busy       <= busy_mid | issue;
        slot_valid <= valid_n;
        for (int i = 0; i < NS; i++) begin
          slot_page[i] <= page_n[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_type <= in_req_type;
      item_page <= in_page_index;
    end
    if (cmd.commit) begin
      result <= res_next;
    end
  end

endmodule

// ===== hdl/npt_ctrl.sv =====
// ----------------------------------------------------------------------------
// npt_ctrl
// Controller: request handshake, sequencing of the remainder unit, result flag.
// ----------------------------------------------------------------------------
module npt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  npt_pkg::npt_sts_t sts,
  output npt_pkg::npt_cmd_t cmd
);

  npt_pkg::ctrl_state_t state;
  npt_pkg::ctrl_state_t state_next;
  logic                 out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npt_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      npt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = npt_pkg::ST_EXEC;
        end
      end
      npt_pkg::ST_EXEC: begin
        // stale current page needs its remainder before the lookup
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = npt_pkg::ST_DIV;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = npt_pkg::ST_IDLE;
        end
      end
      npt_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_next = npt_pkg::ST_EXEC;
        end
      end
      default: begin
        state_next = npt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== bench/neighbor_prefetch_tag_cache_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neighbor_prefetch_tag_cache_test
// Self-checking bench for the neighbour prefetch tag cache. A tag model of
// the three slots, the current page and the outstanding prefetch predicts
// each response when its request is accepted. A checker compares every
// response field against the oldest prediction. Directed cases cover the
// circular wrap, out-of-range pages and a stale current page. Random phases
// then run over several page counts with random gaps and stalls, a long
// receiver hold-off and full drains of the sender.
// ----------------------------------------------------------------------------
module neighbor_prefetch_tag_cache_test;

  localparam int PG_W        = 16;
  localparam int DRAIN_CYC   = 40;
  localparam int STALL_LIMIT = 3000;
  localparam int NUM_SLOTS   = npt_pkg::NUM_SLOTS;
  localparam int CNT_W       = npt_pkg::CNT_W;
  localparam int SLOT_W      = npt_pkg::SLOT_W;

  logic clk;
  logic rst;

  npt_cfg_if                     cfg_ch ();
  npt_req_if #(.PAGE_BITS(PG_W)) req_ch ();
  npt_rsp_if                     rsp_ch ();

  neighbor_prefetch_tag_cache #(.PAGE_BITS(PG_W)) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // tag model
  logic             tag_valid [NUM_SLOTS];
  logic [PG_W-1:0]  tag_page  [NUM_SLOTS];
  logic [PG_W-1:0]  cur_page;
  logic             pf_busy;
  logic [PG_W-1:0]  pf_page;
  logic [CNT_W-1:0] page_count;

  npt_pkg::npt_rsp_t rsp_expected [$];

  int errors       = 0;
  int n_access     = 0;
  int n_done       = 0;
  int n_hits       = 0;
  int n_stores     = 0;
  int n_prefetch   = 0;
  int n_oor        = 0;
  int n_counts     = 0;
  int quiet_cycles = 0;
  int rx_hold      = 0;
  bit rx_steady    = 1'b0;
  bit tx_steady    = 1'b0;

  function automatic int next_of(input int cur, input int cnt);
    return (cur + 1) % cnt;
  endfunction

  function automatic int prev_of(input int cur, input int cnt);
    return (cur == 0) ? cnt - 1 : (cur - 1) % cnt;
  endfunction

  function automatic bit page_wanted(input int p);
    int c;
    int n;
    c = int'(cur_page);
    n = int'(page_count);
    return (p == c) || (p == next_of(c, n)) || (p == prev_of(c, n));
  endfunction

  // slot written, or -1 when the page is not kept
  function automatic int insert_tag(input int p);
    int  dest;
    bit  found;
    int  i;
    dest  = -1;
    found = 1'b0;
    if (!page_wanted(p))
      return -1;
    for (i = 0; i < NUM_SLOTS; i++)
      if (dest < 0 && (!tag_valid[i] || !page_wanted(int'(tag_page[i]))))
        dest = i;
    // a slot already holding the page wins over a free one
    for (i = 0; i < NUM_SLOTS; i++)
      if (!found && tag_valid[i] && tag_page[i] == p) begin
        dest  = i;
        found = 1'b1;
      end
    if (dest >= 0) begin
      tag_valid[dest] = 1'b1;
      tag_page[dest]  = PG_W'(p);
    end
    return dest;
  endfunction

  function automatic npt_pkg::npt_rsp_t predict_cache(input logic typ,
                                                      input logic [PG_W-1:0] idx);
    npt_pkg::npt_rsp_t r;
    int       p;
    int       d;
    int       nx;
    int       pv;
    int       i;
    bit       have_nx;
    bit       have_pv;
    r = '0;
    p = int'(idx);
    d = -1;
    if (p >= int'(page_count)) begin
      r.out_of_range = 1'b1;
      return r;
    end
    if (typ == npt_pkg::REQ_ACCESS) begin
      cur_page = idx;
      for (i = 0; i < NUM_SLOTS; i++)
        if (!r.hit && tag_valid[i] && tag_page[i] == idx) begin
          r.hit       = 1'b1;
          r.slot_used = SLOT_W'(i);
        end
      if (!r.hit) begin
        r.fetch_now = 1'b1;
        d = insert_tag(p);
      end
    end else begin
      pf_busy = 1'b0;
      d = insert_tag(p);
    end
    if (d >= 0) begin
      r.stored    = 1'b1;
      r.slot_used = SLOT_W'(d);
    end
    if (!pf_busy) begin
      nx      = next_of(int'(cur_page), int'(page_count));
      pv      = prev_of(int'(cur_page), int'(page_count));
      have_nx = 1'b0;
      have_pv = 1'b0;
      for (i = 0; i < NUM_SLOTS; i++)
        if (tag_valid[i]) begin
          if (tag_page[i] == nx) have_nx = 1'b1;
          if (tag_page[i] == pv) have_pv = 1'b1;
        end
      if (!(have_nx && have_pv)) begin
        r.prefetch_issue = 1'b1;
        r.prefetch_page  = PG_W'(have_nx ? pv : nx);
        pf_busy          = 1'b1;
        pf_page          = r.prefetch_page;
      end
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int near_page(input int base, input int cnt);
    return (base + 2 * cnt + int'($urandom_range(0, 4)) - 2) % cnt;
  endfunction

  task automatic send_req(input logic typ, input logic [PG_W-1:0] idx);
    int gap;
    if ($urandom_range(0, 149) == 0)
      tx_steady = !tx_steady;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= typ;
    req_ch.page_index <= idx;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    rsp_expected.push_back(predict_cache(typ, idx));
    if (typ == npt_pkg::REQ_ACCESS)
      n_access++;
    else
      n_done++;
  endtask

  // stop offering and wait for every outstanding response
  task automatic drain_results(input int settle);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_page_count(input logic [CNT_W-1:0] cnt);
    drain_results(DRAIN_CYC);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.page_count <= cnt;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    page_count = cnt;
    n_counts++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random();
    int               r;
    int               cnt;
    logic             typ;
    logic [PG_W-1:0]  idx;
    cnt = int'(page_count);
    r   = $urandom_range(0, 99);
    if (cnt == 0 || r >= 92) begin
      typ = 1'($urandom_range(0, 1));
      idx = PG_W'($urandom_range(0, 65535));
    end else if (r < 35) begin
      typ = npt_pkg::REQ_ACCESS;
      idx = PG_W'(near_page(int'(cur_page), cnt));
    end else if (r < 65) begin
      // normally the completion of the prefetch that is in flight
      typ = npt_pkg::REQ_DONE;
      idx = pf_busy ? pf_page : PG_W'(near_page(int'(cur_page), cnt));
    end else if (r < 75) begin
      typ = npt_pkg::REQ_ACCESS;
      idx = PG_W'($urandom_range(0, cnt - 1));
    end else if (r < 85) begin
      typ = npt_pkg::REQ_DONE;
      idx = PG_W'($urandom_range(0, cnt - 1));
    end else begin
      // just around the top of the page space
      typ = 1'($urandom_range(0, 1));
      idx = PG_W'(cnt - 1 + int'($urandom_range(0, 2)));
    end
    if ($urandom_range(0, 99) == 0)
      drain_results(0);
    send_req(typ, idx);
  endtask

  task automatic run_random(input logic [CNT_W-1:0] cnt, input int n);
    write_page_count(cnt);
    repeat (n) send_random();
  endtask

  // page count still at its reset value of one
  task automatic test_reset_count();
    send_req(npt_pkg::REQ_ACCESS, 16'd0);
    send_req(npt_pkg::REQ_DONE,   16'd0);
    send_req(npt_pkg::REQ_ACCESS, 16'd1);
    send_req(npt_pkg::REQ_ACCESS, 16'hFFFF);
  endtask

  task automatic test_wraparound();
    write_page_count(16'hFFFF);
    send_req(npt_pkg::REQ_ACCESS, 16'hFFFE);
    send_req(npt_pkg::REQ_DONE,   pf_page);
    send_req(npt_pkg::REQ_DONE,   pf_page);
    send_req(npt_pkg::REQ_ACCESS, 16'd0);
    send_req(npt_pkg::REQ_DONE,   pf_page);
    send_req(npt_pkg::REQ_ACCESS, 16'hFFFF);
    send_req(npt_pkg::REQ_DONE,   16'h8000);
    send_req(npt_pkg::REQ_DONE,   16'h5555);
    send_req(npt_pkg::REQ_ACCESS, 16'hAAAA);
  endtask

  // current page left above a lowered page count, then a count of zero
  task automatic test_stale_current();
    send_req(npt_pkg::REQ_ACCESS, 16'd65000);
    write_page_count(16'd100);
    send_req(npt_pkg::REQ_DONE,   16'd1);
    send_req(npt_pkg::REQ_DONE,   16'd99);
    send_req(npt_pkg::REQ_ACCESS, 16'd100);
    write_page_count(16'd0);
    send_req(npt_pkg::REQ_ACCESS, 16'd0);
    send_req(npt_pkg::REQ_DONE,   16'd0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_page_count(16'd12);
    rx_hold   = 80;
    tx_steady = 1'b1;
    repeat (25) send_random();
    tx_steady = 1'b0;
    drain_results(0);
    repeat (10) send_random();
  endtask

  task automatic test_random_counts();
    run_random(16'hFFFF, 200);
    run_random(16'd1, 50);
    run_random(16'd2, 80);
    run_random(16'd3, 120);
    run_random(16'd4, 120);
    run_random(CNT_W'($urandom_range(1000, 65534)), 200);
    run_random(CNT_W'($urandom_range(5, 20)), 280);
  endtask

  task automatic check_field(input string name, input logic [PG_W-1:0] exp_v,
                             input logic [PG_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    npt_pkg::npt_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (rsp_expected.size() == 0) begin
        $display("%0t: response transaction with nothing outstanding", $time);
        errors++;
      end else begin
        want = rsp_expected.pop_front();
        check_field("hit",            PG_W'(want.hit),       PG_W'(rsp_ch.hit));
        check_field("fetch_now",      PG_W'(want.fetch_now), PG_W'(rsp_ch.fetch_now));
        check_field("stored",         PG_W'(want.stored),    PG_W'(rsp_ch.stored));
        check_field("slot_used",      PG_W'(want.slot_used), PG_W'(rsp_ch.slot_used));
        check_field("prefetch_issue", PG_W'(want.prefetch_issue),
                    PG_W'(rsp_ch.prefetch_issue));
        check_field("prefetch_page",  want.prefetch_page,    rsp_ch.prefetch_page);
        check_field("out_of_range",   PG_W'(want.out_of_range),
                    PG_W'(rsp_ch.out_of_range));
        n_hits     += int'(want.hit);
        n_stores   += int'(want.stored);
        n_prefetch += int'(want.prefetch_issue);
        n_oor      += int'(want.out_of_range);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
               $time, quiet_cycles, rsp_expected.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rx_side
    int stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0)
        rx_steady = !rx_steady;
      if (rx_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0)
          stall = pick_gap();
      end
    end
  end

  initial begin : tx_side
    int i;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = npt_pkg::REQ_ACCESS;
    req_ch.page_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.page_count = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_page[i]  = '0;
    end
    cur_page   = '0;
    pf_busy    = 1'b0;
    pf_page    = '0;
    page_count = 16'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_count();
    test_wraparound();
    test_stale_current();
    test_backpressure();
    test_random_counts();

    drain_results(DRAIN_CYC);
    $display("run covered %0d accesses and %0d completions over %0d page count settings",
             n_access, n_done, n_counts);
    $display("responses: %0d hits, %0d stores, %0d prefetches, %0d out of range",
             n_hits, n_stores, n_prefetch, n_oor);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
